// File: hw/rtl/red_pkg.sv
// Package for the rotary encoder edge decoder: widths, codes, tables and shared types.
`default_nettype none
package red_pkg;

  // Width of the internal position counter.
  localparam int POS_WIDTH = 10;

  // Fixed field widths of the channels and the register.
  localparam int LOAD_W    = 10;
  localparam int RES_POS_W = 10;
  localparam int LIMIT_W   = 10;
  localparam int STEP_W    = 2;
  localparam int PHASE_W   = 2;

  // Configuration port.
  localparam int CFG_DW = 32;
  localparam int CFG_AW = 3;

  localparam logic [POS_WIDTH-1:0] POS_MAX     = '1;
  localparam logic [POS_WIDTH-1:0] RESET_POS   = POS_WIDTH'(10);
  localparam logic [LIMIT_W-1:0]   RESET_LIMIT = LIMIT_W'(500);
  localparam logic [STEP_W-1:0]    STEPS_NEEDED = STEP_W'(3);
  localparam logic [PHASE_W-1:0]   PHASE_REST  = '0;

  // Register index, taken from paddr[2].
  typedef enum logic {
    CFG_IDX_UPPER_LIMIT = 1'b0,
    CFG_IDX_NONE        = 1'b1
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ACT_NONE       = 3'd0,
    ACT_CW_STEP    = 3'd1,
    ACT_CCW_STEP   = 3'd2,
    ACT_CW_DETENT  = 3'd3,
    ACT_CCW_DETENT = 3'd4
  } act_t;

  typedef enum logic [1:0] {
    MOV_NONE = 2'd0,
    MOV_CW   = 2'd1,
    MOV_CCW  = 2'd2
  } moved_t;

  // Indexed by {phase, line_is_b, edge_rising}.
  localparam logic [PHASE_W-1:0] NEXT_PHASE_TAB [0:15] = '{
    2'd1, 2'd0, 2'd3, 2'd0,
    2'd1, 2'd0, 2'd2, 2'd1,
    2'd2, 2'd3, 2'd2, 2'd1,
    2'd2, 2'd3, 2'd3, 2'd0
  };

  localparam act_t ACTION_TAB [0:15] = '{
    ACT_CW_STEP,  ACT_NONE,       ACT_CCW_STEP, ACT_NONE,
    ACT_NONE,     ACT_CCW_DETENT, ACT_CW_STEP,  ACT_NONE,
    ACT_NONE,     ACT_CW_STEP,    ACT_NONE,     ACT_CCW_STEP,
    ACT_CCW_STEP, ACT_NONE,       ACT_NONE,     ACT_CW_DETENT
  };

  typedef struct packed {
    logic                func;
    logic                line_is_b;
    logic                edge_rising;
    logic [LOAD_W-1:0]   load_value;
  } item_t;

  typedef struct packed {
    logic [PHASE_W-1:0]   phase;
    logic [STEP_W-1:0]    cw_steps;
    logic [STEP_W-1:0]    ccw_steps;
    logic [POS_WIDTH-1:0] pos_count;
  } dec_state_t;

  typedef struct packed {
    logic [RES_POS_W-1:0] position;
    moved_t               moved;
  } result_t;

endpackage
`default_nettype wire

// File: hw/rtl/red_if.sv
// Valid/ready channel interfaces for the decoder's input items and results.
`default_nettype none
interface red_in_if;
  logic                       valid;
  logic                       ready;
  logic                       func;
  logic                       line_is_b;
  logic                       edge_rising;
  logic [red_pkg::LOAD_W-1:0] load_value;

  modport source (output valid, func, line_is_b, edge_rising, load_value, input ready);
  modport sink   (input valid, func, line_is_b, edge_rising, load_value, output ready);
endinterface

interface red_out_if;
  logic                          valid;
  logic                          ready;
  logic [red_pkg::RES_POS_W-1:0] position;
  logic [1:0]                    moved;

  modport source (output valid, position, moved, input ready);
  modport sink   (input valid, position, moved, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/red_apb.sv
// APB register block holding the upper position limit.
`default_nettype none
module red_apb (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [red_pkg::CFG_AW-1:0]  paddr,
  input  wire logic [red_pkg::CFG_DW-1:0]  pwdata,
  output logic      [red_pkg::CFG_DW-1:0]  prdata,
  output logic                             pready,
  output logic      [red_pkg::LIMIT_W-1:0] upper_limit
);

  logic [red_pkg::LIMIT_W-1:0] upper_limit_r;
  logic [red_pkg::LIMIT_W-1:0] upper_limit_nxt;
  red_pkg::cfg_idx_t           idx;
  logic                        wr_en;

  assign pready = 1'b1;
  assign idx    = red_pkg::cfg_idx_t'(paddr[2]);
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    upper_limit_nxt = upper_limit_r;
    if (wr_en && (idx == red_pkg::CFG_IDX_UPPER_LIMIT)) begin
      upper_limit_nxt = pwdata[red_pkg::LIMIT_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upper_limit_r <= red_pkg::RESET_LIMIT;
    end else begin
      upper_limit_r <= upper_limit_nxt;
    end
  end

  always_comb begin
    case (idx)
      red_pkg::CFG_IDX_UPPER_LIMIT: prdata = red_pkg::CFG_DW'(upper_limit_r);
      default:                      prdata = '0;
    endcase
  end

  assign upper_limit = upper_limit_r;

endmodule
`default_nettype wire

// File: hw/rtl/red_step.sv
// Next-state and result logic for one item: phase table, step counters, position.
`default_nettype none
module red_step (
  input  wire red_pkg::item_t                   item,
  input  wire red_pkg::dec_state_t              cur,
  input  wire logic [red_pkg::LIMIT_W-1:0]      upper_limit,
  output red_pkg::dec_state_t                   nxt,
  output red_pkg::result_t                      res
);

  logic [3:0]                       idx;
  red_pkg::act_t                    act;
  logic [red_pkg::PHASE_W-1:0]      nph;
  logic [red_pkg::POS_WIDTH-1:0]    limit;
  red_pkg::moved_t                  moved;

  assign idx = {cur.phase, item.line_is_b, item.edge_rising};
  assign act = red_pkg::ACTION_TAB[idx];
  assign nph = red_pkg::NEXT_PHASE_TAB[idx];

  // Limit clipped to what the counter can hold.
  always_comb begin
    if (33'(upper_limit) > 33'(red_pkg::POS_MAX)) begin
      limit = red_pkg::POS_MAX;
    end else begin
      limit = red_pkg::POS_WIDTH'(upper_limit);
    end
  end

  always_comb begin
    nxt   = cur;
    moved = red_pkg::MOV_NONE;
    if (item.func) begin
      nxt.pos_count = red_pkg::POS_WIDTH'(item.load_value);
    end else begin
      case (act)
        red_pkg::ACT_CW_STEP: begin
          if (cur.cw_steps < red_pkg::STEPS_NEEDED) nxt.cw_steps = cur.cw_steps + 1'b1;
        end
        red_pkg::ACT_CCW_STEP: begin
          if (cur.ccw_steps < red_pkg::STEPS_NEEDED) nxt.ccw_steps = cur.ccw_steps + 1'b1;
        end
        red_pkg::ACT_CW_DETENT: begin
          if (cur.cw_steps >= red_pkg::STEPS_NEEDED) begin
            nxt.pos_count = (cur.pos_count < limit) ? cur.pos_count + 1'b1 : limit;
            nxt.cw_steps  = '0;
            nxt.ccw_steps = '0;
            moved         = red_pkg::MOV_CW;
          end
        end
        red_pkg::ACT_CCW_DETENT: begin
          if (cur.ccw_steps >= red_pkg::STEPS_NEEDED) begin
            if (cur.pos_count != '0) nxt.pos_count = cur.pos_count - 1'b1;
            nxt.cw_steps  = '0;
            nxt.ccw_steps = '0;
            moved         = red_pkg::MOV_CCW;
          end
        end
        default: ;
      endcase
      nxt.phase = nph;
    end
  end

  assign res.position = red_pkg::RES_POS_W'(nxt.pos_count);
  assign res.moved    = moved;

endmodule
`default_nettype wire

// File: hw/rtl/rotary_encoder_edge_decoder.sv
// Top level of the quadrature rotary encoder edge decoder.
//
//  channel | direction | carries                                   | transfer when
//  in_if   | in        | func, line_is_b, edge_rising, load_value  | valid && ready
//  out_if  | out       | position, moved                           | valid && ready
//  APB     | in/out    | upper_limit at byte address 0             | psel & penable & pwrite
//
// One item per cycle sustained while out_if stays ready; the result is presented on out_if once
// the item has passed through the input register and then the result register.
// The item sits in an input register; the step logic runs between it and the result
// register, and the decoder state is updated as the item moves into the result register.
// Input ready stays high while the input register is empty or the result register is empty
// or being drained, so a stalled output holds one result plus one pending item before
// backpressure reaches in_if.
// Synchronous active-low reset: phase rest, step counters 0, position 10, limit 500.
`default_nettype none
module rotary_encoder_edge_decoder (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  red_in_if.sink                          in_if,
  red_out_if.source                       out_if,
  input  wire logic                       psel,
  input  wire logic                       penable,
  input  wire logic                       pwrite,
  input  wire logic [red_pkg::CFG_AW-1:0] paddr,
  input  wire logic [red_pkg::CFG_DW-1:0] pwdata,
  output logic      [red_pkg::CFG_DW-1:0] prdata,
  output logic                            pready
);

  logic [red_pkg::LIMIT_W-1:0] upper_limit;

  // Input register (payload unreset).
  logic                 in_v_r;
  red_pkg::item_t       in_item_r;
  // Result register.
  logic                 out_v_r;
  red_pkg::result_t     out_res_r;
  // Decoder state.
  red_pkg::dec_state_t  st_r;
  red_pkg::dec_state_t  st_nxt;
  red_pkg::result_t     res_nxt;

  logic           advance;   // result register can take a new value
  logic           in_xfer;
  red_pkg::item_t in_item;

  red_apb u_apb (
    .clk         (clk),
    .rst_n       (rst_n),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready),
    .upper_limit (upper_limit)
  );

  red_step u_step (
    .item        (in_item_r),
    .cur         (st_r),
    .upper_limit (upper_limit),
    .nxt         (st_nxt),
    .res         (res_nxt)
  );

  assign advance     = !out_v_r || out_if.ready;
  assign in_if.ready = !in_v_r || advance;
  assign in_xfer     = in_if.valid && in_if.ready;

  assign in_item.func        = in_if.func;
  assign in_item.line_is_b   = in_if.line_is_b;
  assign in_item.edge_rising = in_if.edge_rising;
  assign in_item.load_value  = in_if.load_value;

  // Control: valid flags and decoder state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r         <= 1'b0;
      out_v_r        <= 1'b0;
      st_r.phase     <= red_pkg::PHASE_REST;
      st_r.cw_steps  <= '0;
      st_r.ccw_steps <= '0;
      st_r.pos_count <= red_pkg::RESET_POS;
    end else begin
      if (in_if.ready) in_v_r <= in_xfer;
      if (advance) begin
        out_v_r <= in_v_r;
        if (in_v_r) st_r <= st_nxt;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_xfer) in_item_r <= in_item;
    if (advance && in_v_r) out_res_r <= res_nxt;
  end

  assign out_if.valid    = out_v_r;
  assign out_if.position = out_res_r.position;
  assign out_if.moved    = out_res_r.moved;

  // A pending item is never dropped while the output is stalled.
  a_hold_pending: assert property (@(posedge clk) disable iff (!rst_n)
    (in_v_r && !advance) |=> in_v_r)
    else $error("pending item lost under stall");

  // A completed detent always clears both step counters.
  a_detent_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_v_r && (res_nxt.moved != red_pkg::MOV_NONE))
      |=> (st_r.cw_steps == '0) && (st_r.ccw_steps == '0))
    else $error("step counters not cleared after detent");

  // A load item yields no detent.
  a_load_no_move: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && in_v_r && in_item_r.func) |=> (out_res_r.moved == red_pkg::MOV_NONE))
    else $error("load item reported movement");

  // The phase moves only when an edge item is consumed.
  a_phase_stable: assert property (@(posedge clk) disable iff (!rst_n)
    !(advance && in_v_r && !in_item_r.func) |=> $stable(st_r.phase))
    else $error("phase changed without an edge item");

endmodule
`default_nettype wire

// File: tb/rotary_encoder_edge_decoder_tb.sv
// Self-checking testbench for the rotary encoder edge decoder: directed table, random turns.
module rotary_encoder_edge_decoder_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int KNOB_ITEMS     = 600;  // random items, spread over the limit settings
  localparam int LIMIT_SETTINGS = 6;
  localparam int BACKLOG_CYCLES = 200;  // long output hold-off, forces input backpressure
  localparam int DRAIN_CYCLES   = 10;
  localparam int MAX_REPORTS    = 10;
  localparam int N_DIRECTED     = 24;

  localparam logic [red_pkg::POS_WIDTH-1:0] POS_AT_RESET   = 10'd10;
  localparam logic [red_pkg::LIMIT_W-1:0]   LIMIT_AT_RESET = 10'd500;
  localparam logic [1:0]                    STEP_SAT       = 2'd3;

  localparam logic FUNC_EDGE = 1'b0;
  localparam logic FUNC_LOAD = 1'b1;

  // Byte addresses on the register port, index in paddr[2]
  localparam logic [red_pkg::CFG_AW-1:0] ADDR_LIMIT = {red_pkg::CFG_IDX_UPPER_LIMIT, 2'b00};
  localparam logic [red_pkg::CFG_AW-1:0] ADDR_SPARE = {red_pkg::CFG_IDX_NONE, 2'b00};

  // {line_is_b, edge_rising}
  typedef enum logic [1:0] {
    EDGE_A_FALL = 2'b00,
    EDGE_A_RISE = 2'b01,
    EDGE_B_FALL = 2'b10,
    EDGE_B_RISE = 2'b11
  } line_event_t;

  // Encoder phases, named after the line levels
  typedef enum logic [1:0] {
    PH_REST     = 2'd0,
    PH_A_LOW    = 2'd1,
    PH_BOTH_LOW = 2'd2,
    PH_B_LOW    = 2'd3
  } knob_phase_t;

  typedef struct packed {
    logic                          func;
    line_event_t                   ev;
    logic [red_pkg::LOAD_W-1:0]    load;
    logic                          pinned;   // result typed in below
    logic [red_pkg::RES_POS_W-1:0] pos;
    red_pkg::moved_t               mov;
  } dir_row_t;

  localparam line_event_t CW_TURN  [0:3] = '{EDGE_A_FALL, EDGE_B_FALL, EDGE_A_RISE, EDGE_B_RISE};
  localparam line_event_t CCW_TURN [0:3] = '{EDGE_B_FALL, EDGE_A_FALL, EDGE_B_RISE, EDGE_A_RISE};

  // Directed walk from reset. Pinned rows: after reset, full detents, limit clamp,
  // floor at zero, detent with too few steps, loads.
  localparam dir_row_t DIRECTED [0:N_DIRECTED-1] = '{
    '{FUNC_EDGE, EDGE_A_RISE, 10'd0,   1'b1, 10'd10,  red_pkg::MOV_NONE},  // ignored edge at rest
    '{FUNC_EDGE, EDGE_A_FALL, 10'h3ff, 1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_B_FALL, 10'd0,   1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_A_RISE, 10'h3ff, 1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_B_RISE, 10'd0,   1'b1, 10'd11,  red_pkg::MOV_CW},    // clockwise detent
    '{FUNC_EDGE, EDGE_B_FALL, 10'h2aa, 1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_A_FALL, 10'h155, 1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_B_RISE, 10'd0,   1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_A_RISE, 10'd0,   1'b1, 10'd10,  red_pkg::MOV_CCW},   // anticlockwise detent
    '{FUNC_LOAD, EDGE_A_FALL, 10'h3ff, 1'b1, 10'h3ff, red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_A_FALL, 10'd0,   1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_B_FALL, 10'd0,   1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_A_RISE, 10'd0,   1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_B_RISE, 10'd0,   1'b1, 10'd500, red_pkg::MOV_CW},    // above limit: clamp
    '{FUNC_LOAD, EDGE_B_RISE, 10'd0,   1'b1, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_B_FALL, 10'd0,   1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_A_FALL, 10'd0,   1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_B_RISE, 10'd0,   1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_A_RISE, 10'd0,   1'b1, 10'd0,   red_pkg::MOV_CCW},   // floor at zero
    '{FUNC_EDGE, EDGE_A_FALL, 10'd0,   1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_A_RISE, 10'd0,   1'b1, 10'd0,   red_pkg::MOV_NONE},  // too few steps
    '{FUNC_EDGE, EDGE_B_FALL, 10'd0,   1'b0, 10'd0,   red_pkg::MOV_NONE},
    '{FUNC_EDGE, EDGE_B_RISE, 10'd0,   1'b0, 10'd0,   red_pkg::MOV_NONE},  // too few cw steps
    '{FUNC_LOAD, EDGE_B_RISE, 10'h155, 1'b1, 10'h155, red_pkg::MOV_NONE}
  };

  logic                         clk;
  logic                         rst_n;
  logic                         psel;
  logic                         penable;
  logic                         pwrite;
  logic [red_pkg::CFG_AW-1:0]   paddr;
  logic [red_pkg::CFG_DW-1:0]   pwdata;
  logic [red_pkg::CFG_DW-1:0]   prdata;
  logic                         pready;

  red_in_if  in_ch ();
  red_out_if out_ch ();

  // Side-band with each offered item: a typed-in result replaces the prediction
  logic             pin_valid;
  red_pkg::result_t pin_result;

  // Predictor state and its copy of the register
  knob_phase_t                   ph;
  logic [1:0]                    cw_cnt;
  logic [1:0]                    ccw_cnt;
  logic [red_pkg::POS_WIDTH-1:0] pos;
  logic [red_pkg::LIMIT_W-1:0]   limit;

  red_pkg::result_t due_readings [$];

  int  mismatches;
  int  items_in;
  int  cw_detents;
  int  ccw_detents;
  int  loads_in;
  int  limit_writes;
  bit  tx_gaps_on;
  bit  backlog_req;

  rotary_encoder_edge_decoder DUT (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_if   (in_ch),
    .out_if  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run
  initial begin
    #5ms;
    $display("== FAIL ==");
    $finish;
  end

  function automatic void flag_mismatch(string what, int want, int seen);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, want, seen);
  endfunction

  // One item through the decoder: a load sets the position; an edge walks the phase,
  // bumps or clears the step counts and moves the position on a completed detent.
  function automatic red_pkg::result_t advance_knob(red_pkg::item_t it);
    red_pkg::result_t r;
    line_event_t      ev;
    r.moved = red_pkg::MOV_NONE;
    ev = line_event_t'({it.line_is_b, it.edge_rising});
    if (it.func == FUNC_LOAD) begin
      pos = it.load_value;
    end else begin
      case (ph)
        PH_REST: begin
          if (ev == EDGE_A_FALL) begin
            ph = PH_A_LOW;
            if (cw_cnt != STEP_SAT) cw_cnt++;
          end else if (ev == EDGE_B_FALL) begin
            ph = PH_B_LOW;
            if (ccw_cnt != STEP_SAT) ccw_cnt++;
          end
        end
        PH_A_LOW: begin
          if (ev == EDGE_A_RISE) begin
            // anticlockwise detent, counts only after three steps
            ph = PH_REST;
            if (ccw_cnt == STEP_SAT) begin
              if (pos != '0) pos--;
              cw_cnt  = '0;
              ccw_cnt = '0;
              r.moved = red_pkg::MOV_CCW;
            end
          end else if (ev == EDGE_B_FALL) begin
            ph = PH_BOTH_LOW;
            if (cw_cnt != STEP_SAT) cw_cnt++;
          end
        end
        PH_BOTH_LOW: begin
          if (ev == EDGE_A_RISE) begin
            ph = PH_B_LOW;
            if (cw_cnt != STEP_SAT) cw_cnt++;
          end else if (ev == EDGE_B_RISE) begin
            ph = PH_A_LOW;
            if (ccw_cnt != STEP_SAT) ccw_cnt++;
          end
        end
        default: begin
          if (ev == EDGE_A_FALL) begin
            ph = PH_BOTH_LOW;
            if (ccw_cnt != STEP_SAT) ccw_cnt++;
          end else if (ev == EDGE_B_RISE) begin
            // clockwise detent; at or above the limit the position snaps to it
            ph = PH_REST;
            if (cw_cnt == STEP_SAT) begin
              pos     = (pos < limit) ? pos + 1'b1 : limit;
              cw_cnt  = '0;
              ccw_cnt = '0;
              r.moved = red_pkg::MOV_CW;
            end
          end
        end
      endcase
    end
    r.position = pos;
    return r;
  endfunction

  // Watch both channels at the rising edge: check results, predict accepted items
  always @(posedge clk) begin : watch
    red_pkg::result_t due;
    red_pkg::result_t got;
    red_pkg::item_t   it;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        if (due_readings.size() == 0) begin
          flag_mismatch("unexpected result, position", -1, out_ch.position);
        end else begin
          due = due_readings.pop_front();
          if (out_ch.position !== due.position)
            flag_mismatch("position", due.position, out_ch.position);
          if (out_ch.moved !== due.moved)
            flag_mismatch("moved", due.moved, out_ch.moved);
        end
      end
      if (in_ch.valid && in_ch.ready) begin
        it.func        = in_ch.func;
        it.line_is_b   = in_ch.line_is_b;
        it.edge_rising = in_ch.edge_rising;
        it.load_value  = in_ch.load_value;
        got = advance_knob(it);
        due_readings.push_back(pin_valid ? pin_result : got);
        items_in++;
        if (it.func == FUNC_LOAD) loads_in++;
        if (got.moved == red_pkg::MOV_CW)  cw_detents++;
        if (got.moved == red_pkg::MOV_CCW) ccw_detents++;
      end
    end
  end

  // Result side: bursts of always-ready, light stalls, or rare long stalls;
  // one long hold-off on request so the block backs up into its input.
  initial begin : result_sink
    int burst;
    int mode;
    burst = 0;
    mode  = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (backlog_req) begin
        backlog_req = 1'b0;
        repeat (BACKLOG_CYCLES) begin
          out_ch.ready <= 1'b0;
          @(negedge clk);
        end
      end
      if (burst == 0) begin
        burst = $urandom_range(10, 60);
        mode  = $urandom_range(0, 2);
      end
      burst--;
      case (mode)
        0: out_ch.ready <= 1'b1;
        1: out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 19) == 0) begin
            repeat ($urandom_range(15, 40)) begin
              out_ch.ready <= 1'b0;
              @(negedge clk);
            end
          end else begin
            out_ch.ready <= ($urandom_range(0, 1) != 0);
          end
        end
      endcase
    end
  end

  function automatic int sender_gap();
    int r;
    r = $urandom_range(0, 99);
    if (!tx_gaps_on || r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Offer one item and hold it until the transfer; valid stays up for a back-to-back item
  task automatic send_item(red_pkg::item_t it, logic pin, red_pkg::result_t want);
    int gap;
    gap = sender_gap();
    @(negedge clk);
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.func        <= it.func;
    in_ch.line_is_b   <= it.line_is_b;
    in_ch.edge_rising <= it.edge_rising;
    in_ch.load_value  <= it.load_value;
    pin_valid         <= pin;
    pin_result        <= want;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  function automatic red_pkg::item_t edge_item(line_event_t ev);
    red_pkg::item_t it;
    it.func = FUNC_EDGE;
    {it.line_is_b, it.edge_rising} = ev;
    it.load_value = red_pkg::LOAD_W'($urandom);
    return it;
  endfunction

  // Drop valid and wait for every due result, plus the pipeline depth
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (due_readings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [red_pkg::CFG_AW-1:0] addr, logic [red_pkg::LIMIT_W-1:0] value);
    logic [red_pkg::CFG_DW-1:0] data;
    data = red_pkg::CFG_DW'({$urandom, value});  // junk above the register bits
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (addr[2] == red_pkg::CFG_IDX_UPPER_LIMIT) limit = data[red_pkg::LIMIT_W-1:0];
    limit_writes++;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic check_limit_readback();
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= ADDR_LIMIT;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== red_pkg::CFG_DW'(limit))
      flag_mismatch("upper_limit readback", limit, prdata);
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Random part: mostly whole detent turns with random payload bits, some
  // broken turns, stray edges and loads aimed at the limit and the floor.
  task automatic turn_knob(int n);
    int             sent;
    int             pick;
    int             len;
    bit             cw;
    red_pkg::item_t it;
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 85) begin
        cw  = (pick < 50) || (pick >= 75 && $urandom_range(0, 1) == 1);
        len = (pick < 75) ? 4 : $urandom_range(1, 3);
        for (int k = 0; k < len; k++) begin
          send_item(edge_item(cw ? CW_TURN[k] : CCW_TURN[k]), 1'b0, '0);
          sent++;
        end
      end else if (pick < 94) begin
        send_item(edge_item(line_event_t'($urandom_range(0, 3))), 1'b0, '0);
        sent++;
      end else begin
        it = edge_item(line_event_t'($urandom_range(0, 3)));
        it.func = FUNC_LOAD;
        case ($urandom_range(0, 5))
          0:       it.load_value = '0;
          1:       it.load_value = '1;
          2:       it.load_value = limit - 1'b1;
          3:       it.load_value = limit;
          4:       it.load_value = limit + 1'b1;
          default: it.load_value = red_pkg::LOAD_W'($urandom);
        endcase
        send_item(it, 1'b0, '0);
        sent++;
      end
    end
  endtask

  initial begin : stimulus
    logic [red_pkg::LIMIT_W-1:0] limit_plan [0:LIMIT_SETTINGS-1];
    dir_row_t                    row;
    red_pkg::item_t              it;

    // Everything known from time zero, with reset asserted
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.func        = FUNC_EDGE;
    in_ch.line_is_b   = 1'b0;
    in_ch.edge_rising = 1'b0;
    in_ch.load_value  = '0;
    pin_valid         = 1'b0;
    pin_result        = '0;
    backlog_req       = 1'b0;
    tx_gaps_on        = 1'b1;
    ph                = PH_REST;
    cw_cnt            = '0;
    ccw_cnt           = '0;
    pos               = POS_AT_RESET;
    limit             = LIMIT_AT_RESET;
    mismatches        = 0;
    items_in          = 0;
    cw_detents        = 0;
    ccw_detents       = 0;
    loads_in          = 0;
    limit_writes      = 0;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Register at its reset value, then the directed walk
    check_limit_readback();
    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED[i];
      it.func = row.func;
      {it.line_is_b, it.edge_rising} = row.ev;
      it.load_value = row.load;
      send_item(it, row.pinned, red_pkg::result_t'{row.pos, row.mov});
    end
    settle();

    // Extremes first, then one, the reset limit and random ones
    limit_plan[0] = '0;
    limit_plan[1] = '1;
    limit_plan[2] = 10'd1;
    limit_plan[3] = red_pkg::LIMIT_W'($urandom);
    limit_plan[4] = LIMIT_AT_RESET;
    limit_plan[5] = red_pkg::LIMIT_W'($urandom);

    for (int s = 0; s < LIMIT_SETTINGS; s++) begin
      cfg_write(ADDR_LIMIT, limit_plan[s]);
      if (s == 1) begin
        // write to the unused register index must leave the limit alone
        cfg_write(ADDR_SPARE, red_pkg::LIMIT_W'($urandom));
      end
      check_limit_readback();
      tx_gaps_on = (s % 2 == 1);
      if (s == 3) begin
        // sender flat out while the result side holds off
        tx_gaps_on  = 1'b0;
        backlog_req = 1'b1;
      end
      turn_knob(KNOB_ITEMS / LIMIT_SETTINGS);
      settle();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Covered %0d items: %0d clockwise and %0d anticlockwise detents, %0d loads,",
             items_in, cw_detents, ccw_detents, loads_in);
    $display("%0d register writes, limits at both extremes, one %0d-cycle output hold-off.",
             limit_writes, BACKLOG_CYCLES);
    if (mismatches == 0 && due_readings.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("%0d mismatches, %0d results still due", mismatches, due_readings.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
